@@ design/bpa_pkg.sv @@
// Shared types and codes for the buddy page allocator.
`default_nettype none
package bpa_pkg;

    typedef enum logic [1:0] {
        MK_UNUSED = 2'd0,
        MK_FREE   = 2'd1,
        MK_ALLOC  = 2'd2,
        MK_SPLIT  = 2'd3
    } t_mark;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_SIZE = 3'd1;
    localparam logic [2:0] ST_NO_MEM   = 3'd2;
    localparam logic [2:0] ST_BOUNDS   = 3'd3;
    localparam logic [2:0] ST_NULL     = 3'd4;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic CFG_HEAP_BASE = 1'b0;
    localparam logic CFG_HEAP_SIZE = 1'b1;

    localparam logic [31:0] HDR_BYTES      = 32'd8;
    localparam logic [31:0] HEAP_SIZE_RST  = 32'd134217728;

endpackage
`default_nettype wire

@@ design/bpa_req_if.sv @@
// Request channel: command, size and address.
`default_nettype none
interface bpa_req_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [31:0] size_bytes;
    logic [31:0] address;

    modport source (output valid, cmd, size_bytes, address, input ready);
    modport sink   (input valid, cmd, size_bytes, address, output ready);
endinterface
`default_nettype wire

@@ design/bpa_rsp_if.sv @@
// Response channel: status, granted block and counters.
`default_nettype none
interface bpa_rsp_if;
    logic               valid;
    logic               ready;
    logic        [2:0]  status;
    logic        [31:0] user_address;
    logic        [31:0] block_bytes;
    logic        [31:0] alloc_count;
    logic        [31:0] free_count;
    logic signed [31:0] balance;

    modport source (output valid, status, user_address, block_bytes, alloc_count,
                    free_count, balance, input ready);
    modport sink   (input valid, status, user_address, block_bytes, alloc_count,
                    free_count, balance, output ready);
endinterface
`default_nettype wire

@@ design/buddy_page_allocator.sv @@
// Buddy page allocator: node-mark memory walked by a small sequencer.
`default_nettype none
// Binary buddy allocator over an implicit tree of 2-bit node marks held in one
// single-port-write, registered-read memory of 2^(TOP_ORDER+1) entries. After
// reset a clearing pass writes every entry, one per cycle, before the first
// request is taken. Each request is then handled alone, one memory access per
// cycle: an order search, then on allocate a depth-first search with backtrack
// steps and a split per level, or on free a merge per level. PAGE_BYTES must
// be a power of two. A finished response waits in the output register while
// the next request is accepted.
module buddy_page_allocator #(
    parameter int TOP_ORDER  = 15,
    parameter int PAGE_BYTES = 4096
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire         i_cfg_idx,
    input  wire  [31:0] i_cfg_data,
    bpa_req_if.sink     i_req,
    bpa_rsp_if.source   o_rsp
);
    import bpa_pkg::*;

    localparam int NW    = TOP_ORDER + 1;
    localparam int NODES = 1 << NW;
    localparam int LW    = $clog2(TOP_ORDER + 1);
    localparam int PSH   = $clog2(PAGE_BYTES);
    localparam int BW    = (PSH + TOP_ORDER + 1 > 34) ? PSH + TOP_ORDER + 1 : 34;
    localparam int SHW   = $clog2(PSH + TOP_ORDER + 1);
    localparam logic [BW-1:0] PAGE_BLK = BW'(PAGE_BYTES);
    localparam logic [BW-1:0] ROOT_BLK = PAGE_BLK << TOP_ORDER;
    localparam logic [LW-1:0] TOP_LVL  = LW'(TOP_ORDER);

    typedef enum logic [14:0] {
        S_CLEAR   = 15'h0001,
        S_IDLE    = 15'h0002,
        S_ORDER   = 15'h0004,
        S_SEEK_RD = 15'h0008,
        S_SEEK_EV = 15'h0010,
        S_BACK    = 15'h0020,
        S_SPLIT_A = 15'h0040,
        S_SPLIT_B = 15'h0080,
        S_MARK_AL = 15'h0100,
        S_FREE_MK = 15'h0200,
        S_MERGE_R = 15'h0400,
        S_MERGE_E = 15'h0800,
        S_MERGE_B = 15'h1000,
        S_MERGE_P = 15'h2000,
        S_DONE    = 15'h4000
    } t_state;

    t_state r_state;
    logic [NW-1:0] r_clr;
    logic [31:0]   r_base, r_hsize;
    logic          r_cmd;
    logic [31:0]   r_size, r_diff;
    logic [32:0]   r_need;
    logic [BW-1:0] r_blk;
    logic [LW-1:0] r_lvl;    // target order
    logic [LW-1:0] r_level;  // order of current node
    logic [NW-1:0] r_node;
    logic [2:0]    r_st;
    logic [31:0]   r_ua, r_bb;
    logic [31:0]   r_allocs, r_frees;
    logic          r_ov;
    logic [2:0]    r_o_st;
    logic [31:0]   r_o_ua, r_o_bb, r_o_ac, r_o_fc;

    t_mark         mem [NODES];
    t_mark         r_rdata;
    logic          mem_we;
    logic [NW-1:0] mem_waddr, mem_raddr;
    t_mark         mem_wdata;

    logic          accept;
    logic [31:0]   hdr;
    logic [NW-1:0] bud;
    logic [NW-1:0] alloc_idx;
    logic [31:0]   alloc_off;
    logic [SHW-1:0] free_sh;

    assign accept      = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign hdr         = i_req.address - HDR_BYTES;
    assign bud         = r_node ^ NW'(1);
    assign alloc_idx   = r_node ^ (NW'(1) << (TOP_LVL - r_lvl));
    assign alloc_off   = 32'(alloc_idx) << (SHW'(PSH) + SHW'(r_lvl));
    assign free_sh     = SHW'(PSH) + SHW'(r_lvl);

    assign o_rsp.valid        = r_ov;
    assign o_rsp.status       = r_o_st;
    assign o_rsp.user_address = r_o_ua;
    assign o_rsp.block_bytes  = r_o_bb;
    assign o_rsp.alloc_count  = r_o_ac;
    assign o_rsp.free_count   = r_o_fc;
    assign o_rsp.balance      = $signed(r_o_ac - r_o_fc);

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_node;
        mem_wdata = MK_UNUSED;
        mem_raddr = r_node;
        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = (r_clr == NW'(1)) ? MK_FREE : MK_UNUSED;
            end
            S_SPLIT_A: begin
                mem_we    = 1'b1;
                mem_wdata = MK_SPLIT;
            end
            S_SPLIT_B: begin
                mem_we    = 1'b1;
                mem_waddr = {r_node[NW-2:0], 1'b1};
                mem_wdata = MK_FREE;
            end
            S_MARK_AL: begin
                mem_we    = 1'b1;
                mem_wdata = MK_ALLOC;
            end
            S_FREE_MK: begin
                mem_we    = 1'b1;
                mem_wdata = MK_FREE;
            end
            S_MERGE_R: mem_raddr = bud;
            S_MERGE_E: begin
                mem_we    = (r_rdata == MK_FREE);
                mem_wdata = MK_UNUSED;
            end
            S_MERGE_B: begin
                mem_we    = 1'b1;
                mem_waddr = bud;
                mem_wdata = MK_UNUSED;
            end
            S_MERGE_P: begin
                mem_we    = 1'b1;
                mem_waddr = r_node >> 1;
                mem_wdata = MK_FREE;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        r_rdata <= mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_base   <= '0;
            r_hsize  <= HEAP_SIZE_RST;
            r_allocs <= '0;
            r_frees  <= '0;
            r_ov     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_HEAP_BASE) r_base <= i_cfg_data;
                else r_hsize <= i_cfg_data;
            end
            if (r_ov && o_rsp.ready && r_state != S_DONE) r_ov <= 1'b0;

            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + NW'(1);
                    if (r_clr == '1) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (accept) begin
                        r_cmd  <= i_req.cmd;
                        r_size <= i_req.size_bytes;
                        r_diff <= hdr - r_base;
                        r_ua   <= '0;
                        r_bb   <= '0;
                        r_blk  <= PAGE_BLK;
                        r_lvl  <= '0;
                        if (i_req.cmd == CMD_ALLOC) begin
                            r_need <= {1'b0, i_req.size_bytes} + 33'(HDR_BYTES);
                            if (i_req.size_bytes == '0 || i_req.size_bytes > r_hsize) begin
                                r_st    <= ST_BAD_SIZE;
                                r_state <= S_DONE;
                            end else begin
                                r_st    <= ST_OK;
                                r_state <= S_ORDER;
                            end
                        end else begin
                            r_need <= {1'b0, i_req.size_bytes};
                            if (i_req.address == '0) begin
                                r_st    <= ST_NULL;
                                r_state <= S_DONE;
                            end else if (hdr < r_base ||
                                         {1'b0, hdr} >= {1'b0, r_base} + {1'b0, r_hsize}) begin
                                r_st    <= ST_BOUNDS;
                                r_state <= S_DONE;
                            end else begin
                                r_st    <= ST_OK;
                                r_state <= S_ORDER;
                            end
                        end
                    end
                end
                S_ORDER: begin
                    if (r_blk < BW'(r_need) && r_lvl < TOP_LVL) begin
                        r_blk <= r_blk << 1;
                        r_lvl <= r_lvl + LW'(1);
                    end else if (r_blk < BW'(r_need)) begin
                        r_st    <= ST_BAD_SIZE;
                        r_state <= S_DONE;
                    end else if (r_cmd == CMD_ALLOC) begin
                        r_node  <= NW'(1);
                        r_level <= TOP_LVL;
                        r_state <= S_SEEK_RD;
                    end else if (r_size == '0) begin
                        r_st    <= ST_BAD_SIZE;
                        r_state <= S_DONE;
                    end else if (BW'(r_diff) >= ROOT_BLK) begin
                        // block index past the end of its tree level
                        r_st    <= ST_BOUNDS;
                        r_state <= S_DONE;
                    end else begin
                        r_node  <= (NW'(1) << (TOP_LVL - r_lvl)) | NW'(r_diff >> free_sh);
                        r_state <= S_FREE_MK;
                    end
                end
                S_SEEK_RD: r_state <= S_SEEK_EV;
                S_SEEK_EV: begin
                    if (r_rdata == MK_FREE) begin
                        r_state <= (r_level > r_lvl) ? S_SPLIT_A : S_MARK_AL;
                    end else if (r_rdata == MK_SPLIT && r_level != r_lvl && r_level != '0) begin
                        r_node  <= r_node << 1;
                        r_level <= r_level - LW'(1);
                        r_state <= S_SEEK_RD;
                    end else begin
                        r_state <= S_BACK;
                    end
                end
                S_BACK: begin
                    // climb while on a right child, then step to the right sibling; at the root, fail with no memory
                    if (r_node == NW'(1)) begin
                        r_st    <= ST_NO_MEM;
                        r_state <= S_DONE;
                    end else if (r_node[0]) begin
                        r_node  <= r_node >> 1;
                        r_level <= r_level + LW'(1);
                    end else begin
                        r_node  <= r_node | NW'(1);
                        r_state <= S_SEEK_RD;
                    end
                end
                S_SPLIT_A: r_state <= S_SPLIT_B;
                S_SPLIT_B: begin
                    r_node  <= r_node << 1;
                    r_level <= r_level - LW'(1);
                    r_state <= (r_level - LW'(1) > r_lvl) ? S_SPLIT_A : S_MARK_AL;
                end
                S_MARK_AL: begin
                    r_allocs <= r_allocs + 32'd1;
                    r_ua     <= r_base + alloc_off + HDR_BYTES;
                    r_bb     <= r_blk[31:0];
                    r_state  <= S_DONE;
                end
                S_FREE_MK: begin
                    r_frees <= r_frees + 32'd1;
                    r_state <= (r_node == NW'(1)) ? S_DONE : S_MERGE_R;
                end
                S_MERGE_R: r_state <= S_MERGE_E;
                S_MERGE_E: r_state <= (r_rdata == MK_FREE) ? S_MERGE_B : S_DONE;
                S_MERGE_B: r_state <= S_MERGE_P;
                S_MERGE_P: begin
                    r_node  <= r_node >> 1;
                    r_state <= ((r_node >> 1) == NW'(1)) ? S_DONE : S_MERGE_R;
                end
                S_DONE: begin
                    if (!r_ov || o_rsp.ready) begin
                        r_ov    <= 1'b1;
                        r_o_st  <= r_st;
                        r_o_ua  <= r_ua;
                        r_o_bb  <= r_bb;
                        r_o_ac  <= r_allocs;
                        r_o_fc  <= r_frees;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_CLEAR;
            endcase
        end
    end

    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !mem_we)
        else $error("node memory written while idle");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !i_req.ready)
        else $error("second request taken while one is in work");

    a_node_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEEK_RD || r_state == S_FREE_MK) |-> r_node != '0)
        else $error("tree walk reached node zero");

endmodule
`default_nettype wire
